[rtl/core/tssr_pkg.sv]
package tssr_pkg;

    localparam int PATTERN_BYTES_DEF    = 8192;
    localparam int NAME_TABLE_BYTES_DEF = 4096;
    localparam int SPRITE_SLOTS         = 8;
    localparam int LINE_PIXELS          = 256;
    localparam int LINE_BUF_LEN         = LINE_PIXELS + 8;
    localparam int LINE_BUF_AW          = 9;
    localparam int SLOT_PIX_DEPTH       = SPRITE_SLOTS * 64;
    localparam int SLOT_PIX_AW          = 9;
    localparam int OAM_BYTES            = 256;
    localparam int PIXEL_W              = 5;

    localparam logic [9:0] ATTR_BASE    = 10'h3C0;
    localparam logic [8:0] VISIBLE_ROWS = 9'd240;
    localparam logic [3:0] ROW_IDLE     = 4'd8;

    localparam logic [2:0] OP_PAT_WR = 3'd0;
    localparam logic [2:0] OP_NT_WR  = 3'd1;
    localparam logic [2:0] OP_OAM_WR = 3'd2;
    localparam logic [2:0] OP_RENDER = 3'd3;
    localparam logic [2:0] OP_FRAME  = 3'd4;

    localparam logic [1:0] REG_CONTROL  = 2'd0;
    localparam logic [1:0] REG_SCROLL_X = 2'd1;
    localparam logic [1:0] REG_SCROLL_Y = 2'd2;
    localparam logic [1:0] REG_VMIRROR  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_NAME,
        ST_T_PAT,
        ST_T_HI,
        ST_T_PAL,
        ST_T_PIX,
        ST_S_Y,
        ST_S_CMP,
        ST_S_TILE,
        ST_S_ATTR,
        ST_S_X,
        ST_R_LO,
        ST_R_HI,
        ST_R_GET,
        ST_R_WR,
        ST_O_CHK,
        ST_O_RD,
        ST_O_WR,
        ST_G_RD,
        ST_G_CAP,
        ST_G_OUT
    } state_t;

    function automatic logic [PIXEL_W-1:0] pix(input logic [7:0] lo, input logic [7:0] hi,
                                               input logic [2:0] bit_sel, input logic sprite,
                                               input logic [1:0] pal);
        logic [1:0] c;
        c = {hi[bit_sel], lo[bit_sel]};
        return (c != 2'd0) ? {sprite, pal, c} : '0;
    endfunction

endpackage

[rtl/core/tssr_ram.sv]
module tssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/tile_sprite_scanline_renderer.sv]
// Renders one 256-pixel scanline per render request and returns it as 32 result
// requests of 8 pixels each; write requests load pattern, name table and sprite
// memory, and a frame start request resets the line counter. Each memory has a
// single read port, so a render goes step by step: for each background tile it
// fetches the name, pattern and attribute bytes and writes the tile's pixels;
// it then scans the sprites, loads matching ones into slots, overlays the slot
// pixels and returns the result groups, waiting while the output is stalled.
// The user must write configuration only while no render runs (not enforced).
module tile_sprite_scanline_renderer #(
    parameter int PATTERN_BYTES    = tssr_pkg::PATTERN_BYTES_DEF,
    parameter int NAME_TABLE_BYTES = tssr_pkg::NAME_TABLE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], address[15:3], data[23:16]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // group_index[4:0], pixel_a..pixel_h[44:5], sprite_overflow[45], zero[47:46]
    output logic [47:0] m_tdata,
    output logic        m_tlast
);

    localparam int PAW = $clog2(PATTERN_BYTES);
    localparam int NAW = $clog2(NAME_TABLE_BYTES);
    localparam int PW  = tssr_pkg::PIXEL_W;

    tssr_pkg::state_t state_reg, state_next;

    logic [7:0] control_reg, scroll_x_reg, scroll_y_reg;
    logic       vmirror_reg;

    logic [3:0] slot_row_reg    [tssr_pkg::SPRITE_SLOTS];
    logic [3:0] slot_row_next   [tssr_pkg::SPRITE_SLOTS];
    logic       slot_behind_reg [tssr_pkg::SPRITE_SLOTS];
    logic       slot_behind_next[tssr_pkg::SPRITE_SLOTS];
    logic [7:0] slot_x_reg      [tssr_pkg::SPRITE_SLOTS];
    logic [7:0] slot_x_next     [tssr_pkg::SPRITE_SLOTS];
    logic [2:0] slot_ptr_reg, slot_ptr_next;
    logic [7:0] line_reg, line_next;
    logic       ovf_reg, ovf_next;

    logic [8:0] cl_reg, cl_next;
    logic       ntx_reg, ntx_next, nty_reg, nty_next;
    logic [4:0] col_reg, col_next;
    logic [5:0] tile_cnt_reg, tile_cnt_next;
    logic [2:0] j_reg, j_next;
    logic [8:0] cnt_reg, cnt_next;
    logic [7:0] tile_reg, tile_next;
    logic [7:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [1:0] pal_reg, pal_next;
    logic [7:0] attr_reg, attr_next;
    logic [6:0] spr_n_reg, spr_n_next;
    logic [2:0] row_reg, row_next;
    logic [2:0] slot_k_reg, slot_k_next;
    logic [4:0] grp_reg, grp_next;
    logic [PW-1:0] grp_pix_reg [8];
    logic [PW-1:0] grp_pix_next[8];

    logic          pat_we, nt_we, oam_we, lb_we, sp_we;
    logic [PAW-1:0] pat_waddr, pat_raddr;
    logic [NAW-1:0] nt_waddr, nt_raddr;
    logic [7:0]    oam_waddr, oam_raddr;
    logic [tssr_pkg::LINE_BUF_AW-1:0] lb_waddr, lb_raddr;
    logic [tssr_pkg::SLOT_PIX_AW-1:0] sp_waddr, sp_raddr;
    logic [PW-1:0] lb_wdata, sp_wdata, lb_rdata, sp_rdata;
    logic [7:0]    pat_rdata, nt_rdata, oam_rdata;

    logic        accept;
    logic [2:0]  in_op;
    logic [12:0] in_addr;
    logic [7:0]  in_data;
    logic [12:0] tile_nt_addr, attr_nt_addr;
    logic [11:0] nt_sel;
    logic [2:0]  attr_sh;
    logic [7:0]  attr_shifted;
    logic [7:0]  spr_base;
    logic [2:0]  spr_r;
    logic [2:0]  spr_bit;
    logic [8:0]  ovl_pos;
    logic [8:0]  cl_sum;
    logic        cl_wrap;
    logic        spr_match;
    logic [6:0]  spr_n_inc, spr_n_skip;

    assign accept  = s_tvalid && s_tready;
    assign in_op   = s_tdata[2:0];
    assign in_addr = s_tdata[15:3];
    assign in_data = s_tdata[23:16];

    assign nt_sel       = {nty_reg, ntx_reg, 10'd0};
    assign tile_nt_addr = 13'({cl_reg[8:3], 5'd0}) + 13'(col_reg) + 13'(nt_sel);
    assign attr_nt_addr = 13'(tssr_pkg::ATTR_BASE) + 13'({cl_reg[7:5], 3'd0})
                        + 13'(col_reg[4:2]) + 13'(nt_sel);
    assign attr_sh      = {cl_reg[4], col_reg[1], 1'b0};
    assign attr_shifted = nt_rdata >> attr_sh;
    assign spr_base     = {spr_n_reg[5:0], 2'b00};
    assign spr_r        = attr_reg[7] ? ~row_reg : row_reg;
    assign spr_bit      = attr_reg[6] ? j_reg : ~j_reg;
    assign ovl_pos      = {1'b0, slot_x_reg[slot_k_reg]} + 9'(j_reg);
    assign cl_sum       = {1'b0, line_reg} + {1'b0, scroll_y_reg};
    assign cl_wrap      = cl_sum >= tssr_pkg::VISIBLE_ROWS;
    assign spr_match    = ({1'b0, oam_rdata} + 9'd1) == {1'b0, line_reg};
    assign spr_n_inc    = spr_n_reg + 7'd1;
    assign spr_n_skip   = {spr_n_reg[6:1] + 6'd1, 1'b0};

    tssr_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat_ram (
        .aclk(aclk), .we(pat_we), .waddr(pat_waddr), .wdata(in_data),
        .raddr(pat_raddr), .rdata(pat_rdata)
    );

    tssr_ram #(.WIDTH(8), .DEPTH(NAME_TABLE_BYTES)) u_nt_ram (
        .aclk(aclk), .we(nt_we), .waddr(nt_waddr), .wdata(in_data),
        .raddr(nt_raddr), .rdata(nt_rdata)
    );

    tssr_ram #(.WIDTH(8), .DEPTH(tssr_pkg::OAM_BYTES)) u_oam_ram (
        .aclk(aclk), .we(oam_we), .waddr(oam_waddr), .wdata(in_data),
        .raddr(oam_raddr), .rdata(oam_rdata)
    );

    tssr_ram #(.WIDTH(PW), .DEPTH(tssr_pkg::LINE_BUF_LEN)) u_line_ram (
        .aclk(aclk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
        .raddr(lb_raddr), .rdata(lb_rdata)
    );

    tssr_ram #(.WIDTH(PW), .DEPTH(tssr_pkg::SLOT_PIX_DEPTH)) u_slot_ram (
        .aclk(aclk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
        .raddr(sp_raddr), .rdata(sp_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tssr_pkg::ST_IDLE: begin
                if (accept && in_op == tssr_pkg::OP_RENDER) begin
                    state_next = tssr_pkg::ST_T_NAME;
                end
            end
            tssr_pkg::ST_T_NAME: state_next = tssr_pkg::ST_T_PAT;
            tssr_pkg::ST_T_PAT:  state_next = tssr_pkg::ST_T_HI;
            tssr_pkg::ST_T_HI:   state_next = tssr_pkg::ST_T_PAL;
            tssr_pkg::ST_T_PAL:  state_next = tssr_pkg::ST_T_PIX;
            tssr_pkg::ST_T_PIX: begin
                if (j_reg == 3'd7) begin
                    state_next = (tile_cnt_reg == 6'd32) ? tssr_pkg::ST_S_Y
                                                         : tssr_pkg::ST_T_NAME;
                end
            end
            tssr_pkg::ST_S_Y: state_next = tssr_pkg::ST_S_CMP;
            tssr_pkg::ST_S_CMP: begin
                if (spr_match && slot_row_reg[slot_ptr_reg] == tssr_pkg::ROW_IDLE) begin
                    state_next = tssr_pkg::ST_S_TILE;
                end else if (spr_match) begin
                    state_next = spr_n_skip[6] ? tssr_pkg::ST_O_CHK : tssr_pkg::ST_S_Y;
                end else begin
                    state_next = spr_n_inc[6] ? tssr_pkg::ST_O_CHK : tssr_pkg::ST_S_Y;
                end
            end
            tssr_pkg::ST_S_TILE: state_next = tssr_pkg::ST_S_ATTR;
            tssr_pkg::ST_S_ATTR: state_next = tssr_pkg::ST_S_X;
            tssr_pkg::ST_S_X:    state_next = tssr_pkg::ST_R_LO;
            tssr_pkg::ST_R_LO:   state_next = tssr_pkg::ST_R_HI;
            tssr_pkg::ST_R_HI:   state_next = tssr_pkg::ST_R_GET;
            tssr_pkg::ST_R_GET:  state_next = tssr_pkg::ST_R_WR;
            tssr_pkg::ST_R_WR: begin
                if (j_reg == 3'd7 && row_reg == 3'd7) begin
                    state_next = spr_n_inc[6] ? tssr_pkg::ST_O_CHK : tssr_pkg::ST_S_Y;
                end else if (j_reg == 3'd7) begin
                    state_next = tssr_pkg::ST_R_LO;
                end
            end
            tssr_pkg::ST_O_CHK: begin
                if (slot_row_reg[slot_k_reg][3]) begin
                    state_next = (slot_k_reg == 3'd7) ? tssr_pkg::ST_G_RD
                                                      : tssr_pkg::ST_O_CHK;
                end else begin
                    state_next = tssr_pkg::ST_O_RD;
                end
            end
            tssr_pkg::ST_O_RD: state_next = tssr_pkg::ST_O_WR;
            tssr_pkg::ST_O_WR: begin
                if (j_reg == 3'd7) begin
                    state_next = (slot_k_reg == 3'd7) ? tssr_pkg::ST_G_RD
                                                      : tssr_pkg::ST_O_CHK;
                end else begin
                    state_next = tssr_pkg::ST_O_RD;
                end
            end
            tssr_pkg::ST_G_RD: state_next = tssr_pkg::ST_G_CAP;
            tssr_pkg::ST_G_CAP: begin
                state_next = (j_reg == 3'd7) ? tssr_pkg::ST_G_OUT : tssr_pkg::ST_G_RD;
            end
            tssr_pkg::ST_G_OUT: begin
                if (m_tready) begin
                    state_next = (grp_reg == 5'd31) ? tssr_pkg::ST_IDLE : tssr_pkg::ST_G_RD;
                end
            end
            default: state_next = tssr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = state_reg == tssr_pkg::ST_IDLE;
        m_tvalid  = state_reg == tssr_pkg::ST_G_OUT;
        m_tlast   = grp_reg == 5'd31;
        m_tdata   = {2'b00, ovf_reg, grp_pix_reg[7], grp_pix_reg[6], grp_pix_reg[5],
                     grp_pix_reg[4], grp_pix_reg[3], grp_pix_reg[2], grp_pix_reg[1],
                     grp_pix_reg[0], grp_reg};
        pat_we    = accept && in_op == tssr_pkg::OP_PAT_WR;
        nt_we     = accept && in_op == tssr_pkg::OP_NT_WR;
        oam_we    = accept && in_op == tssr_pkg::OP_OAM_WR;
        pat_waddr = in_addr[PAW-1:0];
        nt_waddr  = in_addr[NAW-1:0];
        oam_waddr = in_addr[7:0];
        pat_raddr = '0;
        nt_raddr  = '0;
        oam_raddr = '0;
        lb_we     = 1'b0;
        lb_waddr  = '0;
        lb_wdata  = '0;
        lb_raddr  = '0;
        sp_we     = 1'b0;
        sp_waddr  = '0;
        sp_wdata  = '0;
        sp_raddr  = '0;
        unique case (state_reg)
            tssr_pkg::ST_T_NAME: nt_raddr = tile_nt_addr[NAW-1:0];
            tssr_pkg::ST_T_PAT: begin
                pat_raddr = PAW'({control_reg[4], nt_rdata, 1'b0, cl_reg[2:0]});
            end
            tssr_pkg::ST_T_HI: begin
                pat_raddr = PAW'({control_reg[4], tile_reg, 1'b1, cl_reg[2:0]});
                nt_raddr  = attr_nt_addr[NAW-1:0];
            end
            tssr_pkg::ST_T_PIX: begin
                lb_we    = 1'b1;
                lb_waddr = cnt_reg;
                lb_wdata = tssr_pkg::pix(lo_reg, hi_reg, ~j_reg, 1'b0, pal_reg);
            end
            tssr_pkg::ST_S_Y:    oam_raddr = spr_base;
            tssr_pkg::ST_S_CMP:  oam_raddr = spr_base + 8'd1;
            tssr_pkg::ST_S_TILE: oam_raddr = spr_base + 8'd2;
            tssr_pkg::ST_S_ATTR: oam_raddr = spr_base + 8'd3;
            tssr_pkg::ST_R_LO: begin
                pat_raddr = PAW'({control_reg[3], tile_reg, 1'b0, spr_r});
            end
            tssr_pkg::ST_R_HI: begin
                pat_raddr = PAW'({control_reg[3], tile_reg, 1'b1, spr_r});
            end
            tssr_pkg::ST_R_WR: begin
                sp_we    = 1'b1;
                sp_waddr = {slot_ptr_reg, row_reg, j_reg};
                sp_wdata = tssr_pkg::pix(lo_reg, hi_reg, spr_bit, 1'b1, attr_reg[1:0]);
            end
            tssr_pkg::ST_O_RD: begin
                lb_raddr = ovl_pos;
                sp_raddr = {slot_k_reg, slot_row_reg[slot_k_reg][2:0], j_reg};
            end
            tssr_pkg::ST_O_WR: begin
                lb_waddr = ovl_pos;
                lb_wdata = sp_rdata;
                lb_we    = (sp_rdata[1:0] != 2'd0)
                         && !(slot_behind_reg[slot_k_reg] && lb_rdata[1:0] != 2'd0);
            end
            tssr_pkg::ST_G_RD: lb_raddr = {1'b0, grp_reg, j_reg};
            default: begin
            end
        endcase
    end

    always_comb begin
        slot_row_next    = slot_row_reg;
        slot_behind_next = slot_behind_reg;
        slot_x_next      = slot_x_reg;
        grp_pix_next     = grp_pix_reg;
        slot_ptr_next    = slot_ptr_reg;
        line_next        = line_reg;
        ovf_next         = ovf_reg;
        cl_next          = cl_reg;
        ntx_next         = ntx_reg;
        nty_next         = nty_reg;
        col_next         = col_reg;
        tile_cnt_next    = tile_cnt_reg;
        j_next           = j_reg;
        cnt_next         = cnt_reg;
        tile_next        = tile_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        pal_next         = pal_reg;
        attr_next        = attr_reg;
        spr_n_next       = spr_n_reg;
        row_next         = row_reg;
        slot_k_next      = slot_k_reg;
        grp_next         = grp_reg;
        case (state_reg)
            tssr_pkg::ST_IDLE: begin
                if (accept && in_op == tssr_pkg::OP_FRAME) begin
                    line_next = 8'd0;
                end
                if (accept && in_op == tssr_pkg::OP_RENDER) begin
                    cl_next       = cl_wrap ? cl_sum - tssr_pkg::VISIBLE_ROWS : cl_sum;
                    nty_next      = vmirror_reg ? 1'b0 : (control_reg[1] ^ cl_wrap);
                    ntx_next      = vmirror_reg ? control_reg[0] : 1'b0;
                    col_next      = scroll_x_reg[7:3];
                    j_next        = scroll_x_reg[2:0];
                    cnt_next      = 9'd0;
                    tile_cnt_next = 6'd0;
                    spr_n_next    = 7'd0;
                    slot_k_next   = 3'd0;
                    grp_next      = 5'd0;
                end
            end
            tssr_pkg::ST_T_PAT: tile_next = nt_rdata;
            tssr_pkg::ST_T_HI:  lo_next = pat_rdata;
            tssr_pkg::ST_T_PAL: begin
                hi_next  = pat_rdata;
                pal_next = attr_shifted[1:0];
            end
            tssr_pkg::ST_T_PIX: begin
                cnt_next = cnt_reg + 9'd1;
                j_next   = j_reg + 3'd1;
                if (j_reg == 3'd7 && tile_cnt_reg != 6'd32) begin
                    tile_cnt_next = tile_cnt_reg + 6'd1;
                    col_next      = col_reg + 5'd1;
                    ntx_next      = vmirror_reg ? (ntx_reg ^ (col_reg == 5'd31)) : 1'b0;
                end
            end
            tssr_pkg::ST_S_CMP: begin
                if (spr_match && slot_row_reg[slot_ptr_reg] == tssr_pkg::ROW_IDLE) begin
                    ovf_next = 1'b0;
                end else if (spr_match) begin
                    ovf_next   = 1'b1;
                    spr_n_next = spr_n_skip;
                end else begin
                    spr_n_next = spr_n_inc;
                end
            end
            tssr_pkg::ST_S_TILE: tile_next = oam_rdata;
            tssr_pkg::ST_S_ATTR: begin
                attr_next                      = oam_rdata;
                slot_behind_next[slot_ptr_reg] = oam_rdata[5];
                slot_row_next[slot_ptr_reg]    = 4'd0;
            end
            tssr_pkg::ST_S_X: begin
                slot_x_next[slot_ptr_reg] = oam_rdata;
                row_next                  = 3'd0;
            end
            tssr_pkg::ST_R_HI: lo_next = pat_rdata;
            tssr_pkg::ST_R_GET: begin
                hi_next = pat_rdata;
                j_next  = 3'd0;
            end
            tssr_pkg::ST_R_WR: begin
                j_next = j_reg + 3'd1;
                if (j_reg == 3'd7) begin
                    row_next = row_reg + 3'd1;
                    if (row_reg == 3'd7) begin
                        slot_ptr_next = slot_ptr_reg + 3'd1;
                        spr_n_next    = spr_n_inc;
                    end
                end
            end
            tssr_pkg::ST_O_CHK: begin
                j_next = 3'd0;
                if (slot_row_reg[slot_k_reg][3]) begin
                    slot_k_next = slot_k_reg + 3'd1;
                    if (slot_k_reg == 3'd7) begin
                        line_next = line_reg + 8'd1;
                    end
                end
            end
            tssr_pkg::ST_O_WR: begin
                j_next = j_reg + 3'd1;
                if (j_reg == 3'd7) begin
                    slot_row_next[slot_k_reg] = slot_row_reg[slot_k_reg] + 4'd1;
                    slot_k_next               = slot_k_reg + 3'd1;
                    if (slot_k_reg == 3'd7) begin
                        line_next = line_reg + 8'd1;
                    end
                end
            end
            tssr_pkg::ST_G_CAP: begin
                grp_pix_next[j_reg] = lb_rdata;
                j_next              = j_reg + 3'd1;
            end
            tssr_pkg::ST_G_OUT: begin
                if (m_tready) begin
                    grp_next = grp_reg + 5'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tssr_pkg::ST_IDLE;
            control_reg  <= 8'd0;
            scroll_x_reg <= 8'd0;
            scroll_y_reg <= 8'd0;
            vmirror_reg  <= 1'b0;
            slot_ptr_reg <= 3'd0;
            line_reg     <= 8'd0;
            ovf_reg      <= 1'b0;
            for (int i = 0; i < tssr_pkg::SPRITE_SLOTS; i++) begin
                slot_row_reg[i]    <= tssr_pkg::ROW_IDLE;
                slot_behind_reg[i] <= 1'b0;
                slot_x_reg[i]      <= 8'd0;
            end
        end else begin
            state_reg        <= state_next;
            slot_ptr_reg     <= slot_ptr_next;
            line_reg         <= line_next;
            ovf_reg          <= ovf_next;
            slot_row_reg     <= slot_row_next;
            slot_behind_reg  <= slot_behind_next;
            slot_x_reg       <= slot_x_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    tssr_pkg::REG_CONTROL:  control_reg  <= cfg_wdata;
                    tssr_pkg::REG_SCROLL_X: scroll_x_reg <= cfg_wdata;
                    tssr_pkg::REG_SCROLL_Y: scroll_y_reg <= cfg_wdata;
                    tssr_pkg::REG_VMIRROR:  vmirror_reg  <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cl_reg       <= cl_next;
        ntx_reg      <= ntx_next;
        nty_reg      <= nty_next;
        col_reg      <= col_next;
        tile_cnt_reg <= tile_cnt_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        tile_reg     <= tile_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        pal_reg      <= pal_next;
        attr_reg     <= attr_next;
        spr_n_reg    <= spr_n_next;
        row_reg      <= row_next;
        slot_k_reg   <= slot_k_next;
        grp_reg      <= grp_next;
        grp_pix_reg  <= grp_pix_next;
    end

endmodule

[test/tile_sprite_scanline_renderer_checker.sv]
`timescale 1ns / 100ps

module tile_sprite_scanline_renderer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    output int          pending,
    output int          errors
);

    typedef struct {
        logic [4:0] grp;
        logic [4:0] px [8];
        logic       ovf;
        logic       last;
    } group_t;

    group_t groups_due[$];

    logic [7:0] ctrl_q, sx_q, sy_q;
    logic       vmir_q;
    logic [7:0] pat_mem [8192];
    logic [7:0] nt_mem  [4096];
    logic [7:0] oam_mem [256];
    logic [4:0] spr_pix [512];
    logic [3:0] spr_row [8];
    logic       spr_behind [8];
    logic [7:0] spr_x [8];
    logic [2:0] spr_ptr;
    logic [7:0] line_no;
    logic [4:0] line_px [264];
    logic       ovf_q;

    int err_cnt = 0;
    assign errors  = err_cnt;
    assign pending = groups_due.size();

    initial begin
        foreach (pat_mem[i]) pat_mem[i] = '0;
        foreach (nt_mem[i]) nt_mem[i] = '0;
        foreach (oam_mem[i]) oam_mem[i] = '0;
        foreach (spr_pix[i]) spr_pix[i] = '0;
        foreach (line_px[i]) line_px[i] = '0;
    end

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic logic [4:0] shade(logic [7:0] lo, logic [7:0] hi, int unsigned b,
                                         logic [4:0] pal);
        logic [1:0] c;
        c = {hi[b], lo[b]};
        return (c != 2'd0) ? ({3'b000, c} | pal) : 5'd0;
    endfunction

    function automatic void fetch_bg(int unsigned col, int unsigned rb, int unsigned ab,
                                     int unsigned sel, int unsigned cl,
                                     output logic [7:0] lo, output logic [7:0] hi,
                                     output logic [4:0] pal);
        int unsigned tile, a, attr, sh;
        tile = nt_mem[(col + rb + sel) & 4095];
        a = (tile << 4) | (int'(ctrl_q[4]) << 12);
        a += cl & 7;
        lo = pat_mem[a & 8191];
        hi = pat_mem[(a + 8) & 8191];
        attr = nt_mem[(ab + (col >> 2) + sel) & 4095];
        sh = ((cl >> 2) & 4) + (col & 2);
        pal = 5'(((attr >> sh) & 3) << 2);
    endfunction

    function automatic void load_sprites(int unsigned blk);
        int unsigned base, slot, addr, attr, r;
        logic [4:0] pal;
        logic [7:0] lo, hi;
        for (int n = 0; n < 2; n++) begin
            base = ((blk * 2 + n) * 4) & 255;
            slot = spr_ptr;
            if (int'(oam_mem[base]) + 1 != int'(line_no)) continue;
            if (spr_row[slot] != tssr_pkg::ROW_IDLE) begin
                ovf_q = 1'b1;
                return;
            end
            ovf_q = 1'b0;
            spr_row[slot] = 4'd0;
            addr = (int'(oam_mem[base + 1]) << 4) + (int'(ctrl_q[3]) << 12);
            attr = oam_mem[base + 2];
            spr_behind[slot] = attr[5];
            pal = 5'(((attr << 2) & 'h0C) | 'h10);
            spr_x[slot] = oam_mem[base + 3];
            for (int unsigned row = 0; row < 8; row++) begin
                r = attr[7] ? 7 - row : row;
                lo = pat_mem[(addr + r) & 8191];
                hi = pat_mem[(addr + r + 8) & 8191];
                for (int unsigned k = 0; k < 8; k++)
                    spr_pix[slot * 64 + row * 8 + k] = shade(lo, hi, attr[6] ? k : 7 - k, pal);
            end
            spr_ptr = spr_ptr + 3'd1;
        end
    endfunction

    function automatic void render_line();
        int unsigned cl, ny, nx, rb, ab, col, cnt, p;
        logic [7:0] lo, hi;
        logic [4:0] pal, s;
        group_t g;
        cl = int'(line_no) + int'(sy_q);
        ny = int'(ctrl_q[1]) << 11;
        nx = int'(ctrl_q[0]) << 10;
        cnt = 0;
        if (cl >= tssr_pkg::VISIBLE_ROWS) begin
            ny ^= 'h800;
            cl -= tssr_pkg::VISIBLE_ROWS;
        end
        if (vmir_q) ny = 0;
        else nx = 0;
        rb = (cl << 2) & 'hFFE0;
        ab = ((cl >> 2) & 'h38) + tssr_pkg::ATTR_BASE;
        col = sx_q >> 3;
        fetch_bg(col, rb, ab, nx + ny, cl, lo, hi, pal);
        for (int unsigned j = sx_q & 7; j < 8; j++) line_px[cnt++] = shade(lo, hi, 7 - j, pal);
        col++;
        for (int unsigned i = 0; i < 32; i++) begin
            if (col >= 32) begin
                col -= 32;
                nx ^= 'h400;
            end
            if (!vmir_q) nx = 0;
            fetch_bg(col, rb, ab, nx + ny, cl, lo, hi, pal);
            load_sprites(i);
            for (int unsigned j = 0; j < 8; j++)
                if (cnt < 264) line_px[cnt++] = shade(lo, hi, 7 - j, pal);
            col++;
        end
        for (int k = 0; k < 8; k++) begin
            if (spr_row[k] >= tssr_pkg::ROW_IDLE) continue;
            for (int unsigned l = 0; l < 8; l++) begin
                p = int'(spr_x[k]) + l;
                s = spr_pix[k * 64 + spr_row[k] * 8 + l];
                if (spr_behind[k] && line_px[p][1:0] != 2'd0) continue;
                if (s[1:0] != 2'd0) line_px[p] = s;
            end
            spr_row[k] = spr_row[k] + 4'd1;
        end
        line_no = line_no + 8'd1;
        for (int i = 0; i < 32; i++) begin
            g.grp = 5'(i);
            for (int j = 0; j < 8; j++) g.px[j] = line_px[i * 8 + j];
            g.ovf = ovf_q;
            g.last = (i == 31);
            groups_due.push_back(g);
        end
    endfunction

    always @(posedge aclk) begin
        logic [2:0] op;
        logic [12:0] adr;
        logic [7:0] dat;
        group_t g;
        if (!aresetn) begin
            ctrl_q = '0; sx_q = '0; sy_q = '0; vmir_q = 1'b0;
            foreach (spr_row[i]) spr_row[i] = tssr_pkg::ROW_IDLE;
            foreach (spr_behind[i]) spr_behind[i] = 1'b0;
            foreach (spr_x[i]) spr_x[i] = '0;
            spr_ptr = '0; line_no = '0; ovf_q = 1'b0;
            groups_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    tssr_pkg::REG_CONTROL:  ctrl_q = cfg_wdata;
                    tssr_pkg::REG_SCROLL_X: sx_q = cfg_wdata;
                    tssr_pkg::REG_SCROLL_Y: sy_q = cfg_wdata;
                    tssr_pkg::REG_VMIRROR:  vmir_q = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                op = s_tdata[2:0];
                adr = s_tdata[15:3];
                dat = s_tdata[23:16];
                case (op)
                    tssr_pkg::OP_PAT_WR: pat_mem[adr] = dat;
                    tssr_pkg::OP_NT_WR:  nt_mem[adr[11:0]] = dat;
                    tssr_pkg::OP_OAM_WR: oam_mem[adr[7:0]] = dat;
                    tssr_pkg::OP_RENDER: render_line();
                    tssr_pkg::OP_FRAME:  line_no = '0;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (groups_due.size() == 0) begin
                    report("unexpected group", m_tdata[4:0], 0);
                end else begin
                    g = groups_due.pop_front();
                    if (m_tdata[4:0] != g.grp) report("group_index", m_tdata[4:0], g.grp);
                    for (int j = 0; j < 8; j++)
                        if (m_tdata[5 + j * 5 +: 5] != g.px[j])
                            report($sformatf("group %0d pixel %0d", g.grp, j),
                                   m_tdata[5 + j * 5 +: 5], g.px[j]);
                    if (m_tdata[45] != g.ovf) report("sprite_overflow", m_tdata[45], g.ovf);
                    if (m_tlast != g.last) report("last", m_tlast, g.last);
                end
            end
        end
    end

endmodule

[test/tile_sprite_scanline_renderer_tb.sv]
`timescale 1ns / 100ps

module tile_sprite_scanline_renderer_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    int          pending, errors;

    int send_idle = 34;
    int recv_idle = 66;
    logic hold_go = 1'b0;
    int hold_cnt = 0;
    logic [7:0] cur_line = '0;

    always #5 aclk = ~aclk;

    tile_sprite_scanline_renderer dut (.*);

    tile_sprite_scanline_renderer_checker chk (.*);

    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (hold_go && m_tvalid) begin
            hold_go <= 1'b0;
            hold_cnt <= 3000;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send(input logic [2:0] op, input logic [12:0] adr, input logic [7:0] dat);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dat, adr, op};
        do @(posedge aclk); while (!s_tready);
        if (op == tssr_pkg::OP_RENDER) cur_line = cur_line + 8'd1;
        if (op == tssr_pkg::OP_FRAME) cur_line = '0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [7:0] c, input logic [7:0] x, input logic [7:0] y,
                            input logic v);
        cfg_we <= 1'b1;
        cfg_addr <= tssr_pkg::REG_CONTROL; cfg_wdata <= c; @(posedge aclk);
        cfg_addr <= tssr_pkg::REG_SCROLL_X; cfg_wdata <= x; @(posedge aclk);
        cfg_addr <= tssr_pkg::REG_SCROLL_Y; cfg_wdata <= y; @(posedge aclk);
        cfg_addr <= tssr_pkg::REG_VMIRROR; cfg_wdata <= {7'd0, v}; @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Lines stay at 0 to 3, so with the scroll values used every render reads tile row 0.
    task automatic render();
        if (cur_line > 8'd3) begin
            send(tssr_pkg::OP_FRAME, 13'($urandom_range(8191)), 8'($urandom_range(255)));
        end
        send(tssr_pkg::OP_RENDER, 13'($urandom_range(8191)), 8'($urandom_range(255)));
    endtask

    task automatic pat_write(input int i);
        send(tssr_pkg::OP_PAT_WR, 13'({i[4], 8'd0, i[3:0]}), 8'($urandom_range(255)));
    endtask

    task automatic nt_write(input int t, input int k);
        logic [12:0] a;
        logic [7:0] d;
        a = (k < 32) ? 13'(t * 1024 + k) : 13'(t * 1024 + 'h3C0 + k - 32);
        d = (k < 32) ? 8'd0 : 8'($urandom_range(255));
        send(tssr_pkg::OP_NT_WR, a, d);
    endtask

    task automatic oam_write(input int k);
        logic [7:0] d;
        d = 8'($urandom_range(255));
        if (k % 4 == 0) d = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(2));
        if (k % 4 == 1) d = 8'd0;
        send(tssr_pkg::OP_OAM_WR, 13'(k), d);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 30) render();
        else if (r < 35) send(tssr_pkg::OP_FRAME, 13'($urandom_range(8191)),
                              8'($urandom_range(255)));
        else if (r < 55) oam_write(int'($urandom_range(23)));
        else if (r < 70) pat_write(int'($urandom_range(31)));
        else if (r < 90) nt_write(int'($urandom_range(2)), int'($urandom_range(39)));
        else send(3'($urandom_range(7, 5)), 13'($urandom_range(8191)),
                  8'($urandom_range(255)));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_regs(8'h00, 8'h00, 8'h00, 1'b0);

        // Renders read only tile 0 of both pattern halves, the top tile row of three name
        // tables and sprites 0 to 5, so those bytes and every sprite Y are written first.
        for (int i = 0; i < 32; i++) pat_write(i);
        for (int t = 0; t < 3; t++) begin
            for (int k = 0; k < 40; k++) nt_write(t, k);
        end
        for (int k = 0; k < 24; k++) begin
            if (k % 4 == 0) send(tssr_pkg::OP_OAM_WR, 13'(k), 8'((k / 4) % 3));
            else oam_write(k);
        end
        for (int i = 6; i < 64; i++)
            send(tssr_pkg::OP_OAM_WR, 13'(i * 4), 8'($urandom_range(255, 3)));

        send(tssr_pkg::OP_OAM_WR, 13'd2, 8'hE3);
        send(tssr_pkg::OP_OAM_WR, 13'd3, 8'hFF);
        send(3'd5, 13'h1FFF, 8'hFF);
        send(3'd7, 13'd0, 8'd0);
        send(tssr_pkg::OP_FRAME, 13'd0, 8'd0);
        for (int i = 0; i < 8; i++) render();
        settle();

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 0) set_regs(8'hFF, 8'hFF, 8'hF4, 1'b1);
            else set_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                          ($urandom_range(1) == 0) ? 8'($urandom_range(4))
                                                   : 8'($urandom_range(244, 240)),
                          1'($urandom_range(1)));
            send_idle = (ph == 0) ? 34 : (ph == 1) ? 66 : 0;
            recv_idle = (ph == 0) ? 66 : (ph == 1) ? 34 : 0;
            if (ph == 2) hold_go = 1'b1;
            render();
            for (int i = 0; i < 5; i++) random_item();
            settle();
        end

        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

endmodule

[tile_sprite_scanline_renderer.f]
rtl/core/tssr_pkg.sv
rtl/core/tssr_ram.sv
rtl/core/tile_sprite_scanline_renderer.sv
test/tile_sprite_scanline_renderer_checker.sv
test/tile_sprite_scanline_renderer_tb.sv
